// File: src/gbn_pkg.sv
`timescale 1ns / 1ps

package gbn_pkg;

    // Sequence numbers run modulo MAX_SEQ + 1
    localparam int SEQ_W  = 3;
    localparam int CNT_W  = 4;
    localparam int DATA_W = 32;
    localparam int SEQ_DEPTH = 8;

    localparam logic [SEQ_W-1:0] MAX_SEQ = 3'd7;
    localparam logic [CNT_W-1:0] MAX_CNT = 4'd7;

    typedef enum logic [1:0] {
        CMD_PACKET   = 2'd0,
        CMD_FRAME    = 2'd1,
        CMD_CKSUM    = 2'd2,
        CMD_TIMEOUT  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STOP    = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PKT,
        S_DELIVER,
        S_RELEASE,
        S_RS_WAIT,
        S_RS_EMIT,
        S_STATUS
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic start_resend;
        logic send_new;
        logic set_drop;
        logic deliver;
        logic release_frame;
        logic resend;
        logic status;
    } t_ctrl;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic match;
        logic release_ok;
        logic resend_more;
        logic out_free;
    } t_stat;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        seq_inc = (s == MAX_SEQ) ? '0 : s + SEQ_W'(1);
    endfunction

    function automatic logic [SEQ_W-1:0] seq_dec(input logic [SEQ_W-1:0] s);
        seq_dec = (s == '0) ? MAX_SEQ : s - SEQ_W'(1);
    endfunction

    // a <= b < c circularly
    function automatic logic in_window(input logic [SEQ_W-1:0] a,
                                       input logic [SEQ_W-1:0] b,
                                       input logic [SEQ_W-1:0] c);
        in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) ||
                    ((b < c) && (c < a));
    endfunction

endpackage

// File: src/go_back_n_arq_engine.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Fields
// request   in         i_valid / o_ready  i_command, i_payload, i_rx_seq, i_rx_ack
// result    out        o_valid / i_ready  o_kind, o_out_seq, o_out_ack, o_out_data,
//                                         o_network_enable, o_dropped, o_last
//
// One request at a time; each result passes through the output register, and
// each request ends with a status result. A packet sends or is refused, a frame
// delivers and releases, a timeout resends via the registered packet RAM read.
// Reset (synchronous, active low) empties the window; the packet RAM is not cleared.
// A stalled result holds the controller; the next request is taken once the
// status result is loaded, even while it waits to be taken.

module go_back_n_arq_engine #(
    parameter int PACKET_BITS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [1:0]                  i_command,
    input  logic [gbn_pkg::DATA_W-1:0]  i_payload,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_rx_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_rx_ack,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   o_out_seq,
    output logic [gbn_pkg::SEQ_W-1:0]   o_out_ack,
    output logic [gbn_pkg::DATA_W-1:0]  o_out_data,
    output logic                        o_network_enable,
    output logic                        o_dropped,
    output logic                        o_last
);

    import gbn_pkg::*;

    // Packets wider than the port carry only the port's bits
    localparam int STORE_W = (PACKET_BITS < DATA_W) ? PACKET_BITS : DATA_W;

    t_ctrl ctrl;
    t_stat stat;

    gbn_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (stat),
        .o_ctrl    (ctrl),
        .o_ready   (o_ready)
    );

    gbn_dpath #(
        .STORE_W (STORE_W)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_stat           (stat),
        .i_payload        (i_payload),
        .i_rx_seq         (i_rx_seq),
        .i_rx_ack         (i_rx_ack),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_kind           (o_kind),
        .o_out_seq        (o_out_seq),
        .o_out_ack        (o_out_ack),
        .o_out_data       (o_out_data),
        .o_network_enable (o_network_enable),
        .o_dropped        (o_dropped),
        .o_last           (o_last)
    );

endmodule

// File: src/gbn_ram.sv
`timescale 1ns / 1ps

module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, register the read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/gbn_dpath.sv
`timescale 1ns / 1ps

module gbn_dpath #(
    parameter int STORE_W = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gbn_pkg::t_ctrl              i_ctrl,
    output gbn_pkg::t_stat              o_stat,
    input  logic [gbn_pkg::DATA_W-1:0]  i_payload,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_rx_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]   i_rx_ack,
    input  logic                        i_ready,
    output logic                        o_valid,
    output logic [1:0]                  o_kind,
    output logic [gbn_pkg::SEQ_W-1:0]   o_out_seq,
    output logic [gbn_pkg::SEQ_W-1:0]   o_out_ack,
    output logic [gbn_pkg::DATA_W-1:0]  o_out_data,
    output logic                        o_network_enable,
    output logic                        o_dropped,
    output logic                        o_last
);

    import gbn_pkg::*;

    // Window state
    logic [SEQ_W-1:0]   r_nts, n_nts;
    logic [SEQ_W-1:0]   r_oldest, n_oldest;
    logic [SEQ_W-1:0]   r_exp, n_exp;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic               r_drop, n_drop;

    // Latched request
    logic [STORE_W-1:0] r_payload;
    logic [SEQ_W-1:0]   r_rx_seq;
    logic [SEQ_W-1:0]   r_rx_ack;

    // Output register
    logic               r_out_valid, n_out_valid;
    t_kind              r_kind, n_kind;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [SEQ_W-1:0]   r_ack, n_ack;
    logic [DATA_W-1:0]  r_data, n_data;
    logic               r_en, n_en;
    logic               r_drop_o, n_drop_o;
    logic               r_last, n_last;

    logic [STORE_W-1:0] ram_rdata;
    logic [DATA_W-1:0]  payload_ext;
    logic [DATA_W-1:0]  ram_ext;
    logic               emit;

    gbn_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SEQ_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.send_new),
        .i_waddr (r_nts),
        .i_wdata (r_payload),
        .i_raddr (r_nts),
        .o_rdata (ram_rdata)
    );

    // Widen stored packets to the port width
    always_comb begin
        payload_ext = '0;
        payload_ext[STORE_W-1:0] = r_payload;
        ram_ext = '0;
        ram_ext[STORE_W-1:0] = ram_rdata;
    end

    // Status to the controller
    always_comb begin
        o_stat.full        = (r_count >= MAX_CNT);
        o_stat.match       = (r_rx_seq <= MAX_SEQ) && (r_rx_seq == r_exp);
        o_stat.release_ok  = (r_rx_ack <= MAX_SEQ) && (r_count != '0) &&
                             in_window(r_oldest, r_rx_ack, r_nts);
        o_stat.resend_more = (r_idx < r_count);
        o_stat.out_free    = !r_out_valid || i_ready;
    end

    assign emit = i_ctrl.send_new || i_ctrl.deliver || i_ctrl.release_frame ||
                  i_ctrl.resend || i_ctrl.status;

    // Advance window state
    always_comb begin
        n_nts    = r_nts;
        n_oldest = r_oldest;
        n_exp    = r_exp;
        n_count  = r_count;
        n_idx    = r_idx;
        n_drop   = r_drop;
        if (i_ctrl.latch) begin
            n_drop = 1'b0;
        end
        if (i_ctrl.start_resend) begin
            n_nts = r_oldest;
            n_idx = '0;
        end
        if (i_ctrl.set_drop) begin
            n_drop = 1'b1;
        end
        if (i_ctrl.send_new) begin
            n_nts   = seq_inc(r_nts);
            n_count = r_count + CNT_W'(1);
        end
        if (i_ctrl.deliver) begin
            n_exp = seq_inc(r_exp);
        end
        if (i_ctrl.release_frame) begin
            n_oldest = seq_inc(r_oldest);
            n_count  = r_count - CNT_W'(1);
        end
        if (i_ctrl.resend) begin
            n_nts = seq_inc(r_nts);
            n_idx = r_idx + CNT_W'(1);
        end
    end

    // Build the next result
    always_comb begin
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_seq       = r_seq;
        n_ack       = r_ack;
        n_data      = r_data;
        n_en        = r_en;
        n_drop_o    = r_drop_o;
        n_last      = r_last;
        if (emit) begin
            n_out_valid = 1'b1;
            n_kind      = KIND_STATUS;
            n_seq       = '0;
            n_ack       = '0;
            n_data      = '0;
            n_en        = 1'b0;
            n_drop_o    = 1'b0;
            n_last      = 1'b0;
            if (i_ctrl.send_new) begin
                n_kind = KIND_SEND;
                n_seq  = r_nts;
                n_ack  = seq_dec(r_exp);
                n_data = payload_ext;
            end else if (i_ctrl.resend) begin
                n_kind = KIND_SEND;
                n_seq  = r_nts;
                n_ack  = seq_dec(r_exp);
                n_data = ram_ext;
            end else if (i_ctrl.deliver) begin
                n_kind = KIND_DELIVER;
                n_seq  = r_rx_seq;
                n_data = payload_ext;
            end else if (i_ctrl.release_frame) begin
                n_kind = KIND_STOP;
                n_seq  = r_oldest;
            end else begin
                n_en     = (r_count < MAX_CNT);
                n_drop_o = r_drop;
                n_last   = 1'b1;
            end
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nts       <= '0;
            r_oldest    <= '0;
            r_exp       <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_nts       <= n_nts;
            r_oldest    <= n_oldest;
            r_exp       <= n_exp;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.latch) begin
            r_payload <= i_payload[STORE_W-1:0];
            r_rx_seq  <= i_rx_seq;
            r_rx_ack  <= i_rx_ack;
        end
        r_kind   <= n_kind;
        r_seq    <= n_seq;
        r_ack    <= n_ack;
        r_data   <= n_data;
        r_en     <= n_en;
        r_drop_o <= n_drop_o;
        r_last   <= n_last;
    end

    assign o_valid          = r_out_valid;
    assign o_kind           = r_kind;
    assign o_out_seq        = r_seq;
    assign o_out_ack        = r_ack;
    assign o_out_data       = r_data;
    assign o_network_enable = r_en;
    assign o_dropped        = r_drop_o;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("outstanding count above window size");

    a_window_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.status |-> ({1'b0, r_nts - r_oldest} == r_count))
        else $error("window span disagrees with outstanding count");

    a_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (!r_en && !r_drop_o))
        else $error("flag set on a result that is not status");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        emit |-> o_stat.out_free)
        else $error("result loaded over a pending one");
`endif

endmodule

// File: src/gbn_ctrl.sv
`timescale 1ns / 1ps

module gbn_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  logic [1:0]     i_command,
    input  gbn_pkg::t_stat i_stat,
    output gbn_pkg::t_ctrl o_ctrl,
    output logic           o_ready
);

    import gbn_pkg::*;

    t_state r_state, n_state;
    logic   accept;

    assign accept = (r_state == S_IDLE) && i_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (t_cmd'(i_command))
                        CMD_PACKET:  n_state = S_PKT;
                        CMD_FRAME:   n_state = S_DELIVER;
                        CMD_TIMEOUT: n_state = S_RS_WAIT;
                        default:     n_state = S_STATUS;
                    endcase
                end
            end
            S_PKT: begin
                if (i_stat.full || i_stat.out_free) begin
                    n_state = S_STATUS;
                end
            end
            S_DELIVER: begin
                if (!i_stat.match || i_stat.out_free) begin
                    n_state = S_RELEASE;
                end
            end
            S_RELEASE: begin
                if (!i_stat.release_ok) begin
                    n_state = S_STATUS;
                end
            end
            S_RS_WAIT: n_state = S_RS_EMIT;
            S_RS_EMIT: begin
                if (!i_stat.resend_more) begin
                    n_state = S_STATUS;
                end else if (i_stat.out_free) begin
                    n_state = S_RS_WAIT;
                end
            end
            S_STATUS: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_ctrl = '0;
        o_ctrl.latch        = accept;
        o_ctrl.start_resend = accept && (t_cmd'(i_command) == CMD_TIMEOUT);
        case (r_state)
            S_PKT: begin
                o_ctrl.set_drop = i_stat.full;
                o_ctrl.send_new = !i_stat.full && i_stat.out_free;
            end
            S_DELIVER: o_ctrl.deliver = i_stat.match && i_stat.out_free;
            S_RELEASE: o_ctrl.release_frame = i_stat.release_ok && i_stat.out_free;
            S_RS_EMIT: o_ctrl.resend = i_stat.resend_more && i_stat.out_free;
            S_STATUS:  o_ctrl.status = i_stat.out_free;
            default: ;
        endcase
    end

    assign o_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_status_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STATUS && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("status result did not close the request");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_ctrl.send_new, o_ctrl.deliver, o_ctrl.release_frame,
                  o_ctrl.resend, o_ctrl.status}))
        else $error("more than one result loaded in a cycle");

    a_latch_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.latch |-> (o_ready && i_valid))
        else $error("request latched while busy");
`endif

endmodule

// File: tb/go_back_n_arq_engine_checker.sv
`timescale 1ns / 1ps

module go_back_n_arq_engine_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_req_valid,
    input  logic                       i_req_ready,
    input  logic [1:0]                 i_command,
    input  logic [gbn_pkg::DATA_W-1:0] i_payload,
    input  logic [gbn_pkg::SEQ_W-1:0]  i_rx_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]  i_rx_ack,
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic [1:0]                 i_kind,
    input  logic [gbn_pkg::SEQ_W-1:0]  i_out_seq,
    input  logic [gbn_pkg::SEQ_W-1:0]  i_out_ack,
    input  logic [gbn_pkg::DATA_W-1:0] i_out_data,
    input  logic                       i_network_enable,
    input  logic                       i_dropped,
    input  logic                       i_last,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_requests,
    output int                         o_results,
    output int                         o_drops
);

    import gbn_pkg::*;

    typedef struct {
        t_kind             kind;
        logic [SEQ_W-1:0]  seq;
        logic [SEQ_W-1:0]  ack;
        logic [DATA_W-1:0] data;
        logic              en;
        logic              drop;
        logic              last;
    } t_result;

    // Shadow of the sender and receiver windows
    logic [SEQ_W-1:0]  send_seq;
    logic [SEQ_W-1:0]  oldest_seq;
    logic [SEQ_W-1:0]  inbound_seq;
    int                in_flight;
    logic [DATA_W-1:0] frame_copy [SEQ_DEPTH];

    t_result pending_results [$];
    int      mismatch_total = 0;
    int      request_total  = 0;
    int      result_total   = 0;
    int      drop_total     = 0;

    function automatic logic [SEQ_W-1:0] step_seq(input logic [SEQ_W-1:0] s);
        return (s == MAX_SEQ) ? '0 : s + 1'b1;
    endfunction

    // True when x lies in [lo, hi) going around the sequence space
    function automatic logic circ_in_range(input logic [SEQ_W-1:0] lo,
                                           input logic [SEQ_W-1:0] x,
                                           input logic [SEQ_W-1:0] hi);
        logic [SEQ_W-1:0] dx;
        logic [SEQ_W-1:0] dh;
        dx = x - lo;
        dh = hi - lo;
        return dx < dh;
    endfunction

    task automatic push_result(input t_kind kind, input logic [SEQ_W-1:0] seq,
                               input logic [SEQ_W-1:0] ack,
                               input logic [DATA_W-1:0] data,
                               input logic en, input logic drop, input logic last);
        t_result r;
        r.kind = kind;
        r.seq  = seq;
        r.ack  = ack;
        r.data = data;
        r.en   = en;
        r.drop = drop;
        r.last = last;
        pending_results.push_back(r);
    endtask

    // Transmit a stored frame with the current piggybacked ack
    task automatic push_send(input logic [SEQ_W-1:0] seq);
        push_result(KIND_SEND, seq, inbound_seq - 1'b1, frame_copy[seq], 1'b0, 1'b0, 1'b0);
    endtask

    // Work out every result that one request causes
    task automatic apply_request(input t_cmd cmd, input logic [DATA_W-1:0] data,
                                 input logic [SEQ_W-1:0] rseq,
                                 input logic [SEQ_W-1:0] rack);
        logic refused;
        int   i;
        refused = 1'b0;
        case (cmd)
            CMD_PACKET: begin
                if (in_flight >= int'(MAX_CNT)) begin
                    refused = 1'b1;
                    drop_total++;
                end else begin
                    frame_copy[send_seq] = data;
                    in_flight++;
                    push_send(send_seq);
                    send_seq = step_seq(send_seq);
                end
            end
            CMD_FRAME: begin
                if (rseq == inbound_seq) begin
                    push_result(KIND_DELIVER, rseq, '0, data, 1'b0, 1'b0, 1'b0);
                    inbound_seq = step_seq(inbound_seq);
                end
                // release everything up to and including the ack
                while (in_flight > 0 && circ_in_range(oldest_seq, rack, send_seq)) begin
                    push_result(KIND_STOP, oldest_seq, '0, '0, 1'b0, 1'b0, 1'b0);
                    in_flight--;
                    oldest_seq = step_seq(oldest_seq);
                end
            end
            CMD_TIMEOUT: begin
                // go back and resend the whole window, oldest first
                send_seq = oldest_seq;
                for (i = 0; i < in_flight; i++) begin
                    push_send(send_seq);
                    send_seq = step_seq(send_seq);
                end
            end
            default: ;
        endcase
        push_result(KIND_STATUS, '0, '0, '0, in_flight < int'(MAX_CNT), refused, 1'b1);
    endtask

    task automatic note_mismatch(input string what);
        mismatch_total++;
        if (mismatch_total <= 10)
            $display("%0t ns: mismatch: %s", $time, what);
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            send_seq    = '0;
            oldest_seq  = '0;
            inbound_seq = '0;
            in_flight   = 0;
            pending_results.delete();
        end else begin
            // Compare a taken result with the oldest expectation
            if (i_res_valid && i_res_ready) begin
                result_total++;
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected result kind %0d seq %0d ack %0d data %h last %b",
                        i_kind, i_out_seq, i_out_ack, i_out_data, i_last));
                end else begin
                    want = pending_results.pop_front();
                    if (i_kind !== want.kind || i_out_seq !== want.seq ||
                        i_out_ack !== want.ack || i_out_data !== want.data ||
                        i_network_enable !== want.en || i_dropped !== want.drop ||
                        i_last !== want.last)
                        note_mismatch($sformatf({"expected kind %0d seq %0d ack %0d ",
                            "data %h en %b drop %b last %b, got kind %0d seq %0d ",
                            "ack %0d data %h en %b drop %b last %b"},
                            want.kind, want.seq, want.ack, want.data, want.en,
                            want.drop, want.last, i_kind, i_out_seq, i_out_ack,
                            i_out_data, i_network_enable, i_dropped, i_last));
                end
            end
            // Predict the results of a taken request
            if (i_req_valid && i_req_ready) begin
                request_total++;
                apply_request(t_cmd'(i_command), i_payload, i_rx_seq, i_rx_ack);
            end
        end
        o_mismatches <= mismatch_total;
        o_pending    <= pending_results.size();
        o_requests   <= request_total;
        o_results    <= result_total;
        o_drops      <= drop_total;
    end

endmodule

// File: tb/go_back_n_arq_engine_tb.sv
`timescale 1ns / 1ps

module go_back_n_arq_engine_tb;
    import gbn_pkg::*;

    localparam int RANDOM_COUNT = 295;
    localparam int CALM_COUNT   = 50;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_command;
    logic [DATA_W-1:0] i_payload;
    logic [SEQ_W-1:0]  i_rx_seq;
    logic [SEQ_W-1:0]  i_rx_ack;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_kind;
    logic [SEQ_W-1:0]  o_out_seq;
    logic [SEQ_W-1:0]  o_out_ack;
    logic [DATA_W-1:0] o_out_data;
    logic              o_network_enable;
    logic              o_dropped;
    logic              o_last;

    int mismatches;
    int pending;
    int requests;
    int results;
    int drops;

    // Stimulus view of the windows, kept so frames can stay in sequence
    logic [SEQ_W-1:0] peer_seq = '0;
    logic [SEQ_W-1:0] win_base = '0;
    int               win_count = 0;
    bit               calm_tail = 1'b0;

    go_back_n_arq_engine dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_command        (i_command),
        .i_payload        (i_payload),
        .i_rx_seq         (i_rx_seq),
        .i_rx_ack         (i_rx_ack),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_kind           (o_kind),
        .o_out_seq        (o_out_seq),
        .o_out_ack        (o_out_ack),
        .o_out_data       (o_out_data),
        .o_network_enable (o_network_enable),
        .o_dropped        (o_dropped),
        .o_last           (o_last)
    );

    go_back_n_arq_engine_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_req_valid      (i_valid),
        .i_req_ready      (o_ready),
        .i_command        (i_command),
        .i_payload        (i_payload),
        .i_rx_seq         (i_rx_seq),
        .i_rx_ack         (i_rx_ack),
        .i_res_valid      (o_valid),
        .i_res_ready      (i_ready),
        .i_kind           (o_kind),
        .i_out_seq        (o_out_seq),
        .i_out_ack        (o_out_ack),
        .i_out_data       (o_out_data),
        .i_network_enable (o_network_enable),
        .i_dropped        (o_dropped),
        .i_last           (o_last),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_requests       (requests),
        .o_results        (results),
        .o_drops          (drops)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Present one request, optionally after an idle burst, and hold it until taken
    task automatic issue(input t_cmd cmd, input logic [DATA_W-1:0] data,
                         input logic [SEQ_W-1:0] seq, input logic [SEQ_W-1:0] ack);
        logic [SEQ_W-1:0] span;
        if (!calm_tail && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_command <= cmd;
        i_payload <= data;
        i_rx_seq  <= seq;
        i_rx_ack  <= ack;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        // track the windows the request moves
        case (cmd)
            CMD_PACKET: begin
                if (win_count < int'(MAX_CNT))
                    win_count++;
            end
            CMD_FRAME: begin
                if (seq == peer_seq)
                    peer_seq = peer_seq + 1'b1;
                span = ack - win_base;
                if (int'(span) < win_count) begin
                    win_base  = ack + 1'b1;
                    win_count = win_count - int'(span) - 1;
                end
            end
            default: ;
        endcase
    endtask

    // Stall the result side in random bursts, never during the tail
    initial begin : result_sink
        i_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (!calm_tail && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    initial begin : run_limit
        #5_000_000;
        $display("go_back_n_arq_engine_tb failed");
        $finish;
    end

    initial begin : stimulus
        int               n;
        int               pick;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] ack;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_command <= CMD_PACKET;
        i_payload <= '0;
        i_rx_seq  <= '0;
        i_rx_ack  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty window: timeout, checksum error, stray frame
        issue(CMD_TIMEOUT, '0, '0, '0);
        issue(CMD_CKSUM, '1, '1, '1);
        issue(CMD_FRAME, '0, 3'd7, 3'd7);
        // Fill the window, extremes of the packet first
        issue(CMD_PACKET, '0, '0, '0);
        issue(CMD_PACKET, '1, '0, '0);
        for (n = 0; n < 5; n++)
            issue(CMD_PACKET, $urandom, '0, '0);
        // Window full: packet refused
        issue(CMD_PACKET, 32'h5A5A_A5A5, '0, '0);
        // Resend a full window
        issue(CMD_TIMEOUT, '0, '0, '0);
        // In-order delivery whose ack releases the whole window
        issue(CMD_FRAME, '1, 3'd0, 3'd6);
        // Delivery with an ack while the window is empty
        issue(CMD_FRAME, $urandom, 3'd1, 3'd7);
        issue(CMD_PACKET, $urandom, '0, '0);
        issue(CMD_PACKET, $urandom, '0, '0);
        // Out-of-order frame that still releases one frame
        issue(CMD_FRAME, $urandom, 3'd5, 3'd7);
        issue(CMD_TIMEOUT, '0, '0, '0);
        issue(CMD_CKSUM, '0, '0, '0);

        // Random traffic, mostly in sequence with acks inside the window
        for (n = 0; n < RANDOM_COUNT; n++) begin
            if (n == RANDOM_COUNT - CALM_COUNT)
                calm_tail = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                issue(CMD_PACKET, $urandom, 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)));
            end else if (pick < 75) begin
                if (pick < 70) begin
                    seq = ($urandom_range(0, 3) != 0) ? peer_seq : 3'($urandom_range(0, 7));
                    if (win_count > 0 && $urandom_range(0, 4) != 0)
                        ack = win_base + 3'($urandom_range(0, win_count - 1));
                    else
                        ack = 3'($urandom_range(0, 7));
                end else begin
                    seq = 3'($urandom_range(0, 7));
                    ack = 3'($urandom_range(0, 7));
                end
                issue(CMD_FRAME, $urandom, seq, ack);
            end else if (pick < 83) begin
                issue(CMD_CKSUM, $urandom, 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)));
            end else begin
                issue(CMD_TIMEOUT, $urandom, 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)));
            end
        end
        i_valid <= 1'b0;

        // Drain outstanding results, then watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (32) @(posedge i_clk);

        $display("Ran %0d requests of all four commands; checked %0d results,",
                 requests, results);
        $display("with %0d packets refused on a full window.", drops);
        if (mismatches == 0 && pending == 0) begin
            $display("go_back_n_arq_engine_tb passed");
        end else begin
            $display("go_back_n_arq_engine_tb failed");
        end
        $finish;
    end

endmodule
